/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the detector modules.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/smpd_pkg.sv */
// Shared types for the SNR median peak decline detector.
// Command and status groups passed between smpd_ctrl and smpd_datapath, and the register map.
package smpd_pkg;

  typedef enum logic [1:0] {
    SQ_NONE,
    SQ_X,
    SQ_Y,
    SQ_S
  } sq_op_t;

  typedef enum logic [1:0] {
    RD_CAND,
    RD_SCAN,
    RD_MID
  } rd_sel_t;

  typedef enum logic [1:0] {
    REG_SPACING,
    REG_DROP,
    REG_LIMIT,
    REG_WSIZE
  } reg_idx_t;

  typedef struct packed {
    logic    capture;
    logic    diff;
    sq_op_t  sq_op;
    logic    clear;
    logic    insert;
    rd_sel_t rd_sel;
    logic    cand_load;
    logic    scan;
    logic    next_cand;
    logic    peak;
    logic    emit;
  } smpd_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic gate_ok;
    logic have_last;
    logic far;
    logic will_fill;
    logic scan_done;
    logic rank_hit;
    logic out_free;
  } smpd_stat_t;

endpackage

/* hw/rtl/smpd_ctrl.sv */
// Sequencer for the detector: steps one word through gating, window insert,
// rank-based median search and peak update. Depends on smpd_pkg.
`include "assert_macros.svh"

module smpd_ctrl import smpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_ready,
  input  smpd_stat_t stat,
  output smpd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SQX,
    S_SQY,
    S_SQS,
    S_CMP,
    S_INSERT,
    S_RD_CAND,
    S_LD_CAND,
    S_SCAN,
    S_CHECK,
    S_PEAK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign sample_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sq_op  = SQ_NONE;
    cmd.rd_sel = RD_CAND;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = sample_valid;
        if (sample_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.diff = 1'b1;
        priority if (stat.is_clear) begin
          cmd.clear  = 1'b1;
          state_next = S_DONE;
        end else if (!stat.gate_ok) begin
          state_next = S_DONE;
        end else if (!stat.have_last) begin
          state_next = S_INSERT;
        end else begin
          state_next = S_SQX;
        end
      end
      S_SQX: begin
        cmd.sq_op  = SQ_X;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_op  = SQ_Y;
        state_next = S_SQS;
      end
      S_SQS: begin
        cmd.sq_op  = SQ_S;
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = stat.far ? S_INSERT : S_DONE;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = stat.will_fill ? S_RD_CAND : S_DONE;
      end
      S_RD_CAND: begin
        cmd.rd_sel = RD_CAND;
        state_next = S_LD_CAND;
      end
      S_LD_CAND: begin
        cmd.cand_load = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.rd_sel = RD_SCAN;
        if (stat.scan_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        // issue the middle-entry read now so it lands in S_PEAK
        cmd.rd_sel = RD_MID;
        if (stat.rank_hit) begin
          state_next = S_PEAK;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = S_RD_CAND;
        end
      end
      S_PEAK: begin
        cmd.peak   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_SYNC(a_insert_gated, (state == S_INSERT) |-> (stat.gate_ok && !stat.is_clear), "insert without passing gate")
  `ASSERT_SYNC(a_peak_after_hit, (state == S_PEAK) |-> $past(stat.rank_hit), "peak update without median rank hit")

endmodule

/* hw/rtl/smpd_datapath.sv */
// Datapath for the detector: distance check, circular window memory,
// rank-count median search, peak hold, decline counter and result register.
// Depends on smpd_pkg; driven by smpd_ctrl.
`include "assert_macros.svh"

module smpd_datapath import smpd_pkg::*; #(
  parameter int MAX_WINDOW = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  smpd_cmd_t          cmd,
  output smpd_stat_t         stat,
  input  logic [15:0]        spacing,
  input  logic [14:0]        drop_threshold,
  input  logic [7:0]         decline_limit,
  input  logic [3:0]         window_size,
  input  logic               action,
  input  logic               searching,
  input  logic               position_valid,
  input  logic signed [15:0] snr_value,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               sample_taken,
  output logic               filtered_valid,
  output logic signed [15:0] median_snr,
  output logic               new_peak,
  output logic               have_peak,
  output logic signed [15:0] peak_snr,
  output logic signed [15:0] peak_x,
  output logic signed [15:0] peak_y,
  output logic [7:0]         decline_count,
  output logic               return_request
);

  localparam int CW      = $clog2(MAX_WINDOW + 1);
  localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MAX_ODD = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
  localparam int WW      = (CW > 4) ? CW : 4;
  localparam logic [7:0] DECLINE_SAT = 8'hFF;

  typedef struct packed {
    logic signed [15:0] snr;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } entry_t;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_WINDOW)) s = s - (CW+1)'(MAX_WINDOW);
    return AW'(s);
  endfunction

  // captured word
  logic               in_act;
  logic               in_gate;
  logic signed [15:0] in_snr;
  logic signed [15:0] in_px;
  logic signed [15:0] in_py;

  // distance check
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] mul_a;
  logic signed [33:0] prod;
  logic [33:0]        sq;
  logic [34:0]        dist_sum;

  // window and search state
  entry_t             mem [MAX_WINDOW];
  entry_t             rdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      head;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      cand_i;
  logic [CW-1:0]      scan_j;
  logic [CW-1:0]      scan_jq;
  logic               rd_v;
  logic [CW-1:0]      rank_cnt;
  logic signed [15:0] cand;

  // tracking state
  logic signed [15:0] last_px;
  logic signed [15:0] last_py;
  logic               have_last;
  logic signed [15:0] held_snr;
  logic signed [15:0] held_px;
  logic signed [15:0] held_py;
  logic               peak_seen;
  logic [7:0]         declines;
  logic               return_latched;

  // per-word flags
  logic               taken;
  logic               fvalid;
  logic signed [15:0] fsnr;
  logic               newpk;

  // window length and insert math
  logic [WW-1:0]      wodd;
  logic [CW-1:0]      wlen;
  logic               fill_full;
  logic [CW-1:0]      drop_n;
  logic [CW-1:0]      fill_kept;
  logic [AW-1:0]      head_new;
  logic [AW-1:0]      waddr;

  // peak and decline math
  logic signed [16:0] drop_amt;
  logic               decl_up;
  logic [7:0]         decl_next;
  logic               is_less;
  logic               cleared;

  assign wodd = WW'({window_size[3:1], 1'b1});
  assign wlen = (wodd > WW'(MAX_WINDOW)) ? CW'(MAX_ODD) : CW'(wodd);

  assign fill_full = (fill >= wlen);
  assign drop_n    = fill - wlen + CW'(1);
  assign head_new  = fill_full ? wrap(head, drop_n) : head;
  assign fill_kept = fill_full ? wlen - CW'(1) : fill;
  assign waddr     = wrap(head_new, fill_kept);

  always_comb begin
    unique case (cmd.sq_op)
      SQ_X:    mul_a = dx;
      SQ_Y:    mul_a = dy;
      SQ_S:    mul_a = $signed({1'b0, spacing});
      default: mul_a = '0;
    endcase
  end
  assign prod = mul_a * mul_a;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_CAND: raddr = wrap(head, cand_i);
      RD_SCAN: raddr = wrap(head, scan_j);
      RD_MID:  raddr = wrap(head, wlen >> 1);
      default: raddr = head;
    endcase
  end

  // stable rank: smaller values, then equal values earlier in time
  assign is_less = ($signed(rdata.snr) < cand) ||
                   (($signed(rdata.snr) == cand) && (scan_jq < cand_i));

  assign drop_amt  = {held_snr[15], held_snr} - {cand[15], cand};
  assign decl_up   = (drop_amt >= $signed({2'b00, drop_threshold}));
  assign decl_next = decl_up ? ((declines == DECLINE_SAT) ? declines : declines + 8'd1)
                             : 8'd0;

  assign cleared = (fill == '0) && !peak_seen && !return_latched;

  assign stat.is_clear  = !in_act;
  assign stat.gate_ok   = in_gate;
  assign stat.have_last = have_last;
  assign stat.far       = !have_last || (dist_sum >= {1'b0, sq});
  assign stat.will_fill = ((fill_kept + CW'(1)) == wlen);
  assign stat.scan_done = (scan_j == wlen) && !rd_v;
  assign stat.rank_hit  = (rank_cnt == (wlen >> 1));
  assign stat.out_free  = !result_valid || result_ready;

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.insert) mem[waddr] <= '{snr: in_snr, px: in_px, py: in_py};
    rdata <= mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_act  <= action;
      in_gate <= searching & position_valid;
      in_snr  <= snr_value;
      in_px   <= pos_x;
      in_py   <= pos_y;
    end
    if (cmd.diff) begin
      dx <= {in_px[15], in_px} - {last_px[15], last_px};
      dy <= {in_py[15], in_py} - {last_py[15], last_py};
    end
    unique case (cmd.sq_op)
      SQ_X:    sq <= 34'(prod);
      SQ_Y: begin
        dist_sum <= 35'(sq);
        sq       <= 34'(prod);
      end
      SQ_S: begin
        dist_sum <= dist_sum + 35'(sq);
        sq       <= 34'(prod);
      end
      default: ;
    endcase
    if (cmd.cand_load) cand <= rdata.snr;
    if (cmd.scan) scan_jq <= scan_j;
    if (cmd.emit) begin
      sample_taken   <= taken;
      filtered_valid <= fvalid;
      median_snr     <= fsnr;
      new_peak       <= newpk;
      have_peak      <= peak_seen;
      peak_snr       <= held_snr;
      peak_x         <= held_px;
      peak_y         <= held_py;
      decline_count  <= declines;
      return_request <= return_latched;
    end
  end

  // control and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      fill           <= '0;
      cand_i         <= '0;
      scan_j         <= '0;
      rd_v           <= 1'b0;
      rank_cnt       <= '0;
      last_px        <= '0;
      last_py        <= '0;
      have_last      <= 1'b0;
      held_snr       <= '0;
      held_px        <= '0;
      held_py        <= '0;
      peak_seen      <= 1'b0;
      declines       <= '0;
      return_latched <= 1'b0;
      taken          <= 1'b0;
      fvalid         <= 1'b0;
      fsnr           <= '0;
      newpk          <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        taken  <= 1'b0;
        fvalid <= 1'b0;
        fsnr   <= '0;
        newpk  <= 1'b0;
      end
      if (cmd.clear) begin
        head           <= '0;
        fill           <= '0;
        last_px        <= '0;
        last_py        <= '0;
        have_last      <= 1'b0;
        held_snr       <= '0;
        held_px        <= '0;
        held_py        <= '0;
        peak_seen      <= 1'b0;
        declines       <= '0;
        return_latched <= 1'b0;
      end
      if (cmd.insert) begin
        // drop the oldest entries so the new one keeps the window at length
        head      <= head_new;
        fill      <= fill_kept + CW'(1);
        last_px   <= in_px;
        last_py   <= in_py;
        have_last <= 1'b1;
        taken     <= 1'b1;
        cand_i    <= '0;
      end
      if (cmd.cand_load) begin
        scan_j   <= '0;
        rd_v     <= 1'b0;
        rank_cnt <= '0;
      end
      if (cmd.scan) begin
        if (scan_j != wlen) begin
          scan_j <= scan_j + CW'(1);
          rd_v   <= 1'b1;
        end else begin
          rd_v <= 1'b0;
        end
        if (rd_v && is_less) rank_cnt <= rank_cnt + CW'(1);
      end
      if (cmd.next_cand) cand_i <= cand_i + CW'(1);
      if (cmd.peak) begin
        fvalid <= 1'b1;
        fsnr   <= cand;
        if (!peak_seen || (cand > held_snr)) begin
          peak_seen <= 1'b1;
          held_snr  <= cand;
          held_px   <= rdata.px;
          held_py   <= rdata.py;
          declines  <= '0;
          newpk     <= 1'b1;
        end else begin
          declines <= decl_next;
          if (decl_next >= decline_limit) return_latched <= 1'b1;
        end
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `ASSERT_SYNC(a_fill_bound, fill <= CW'(MAX_WINDOW), "window fill beyond capacity")
  `ASSERT_SYNC(a_head_bound, {1'b0, head} < (AW+1)'(MAX_WINDOW), "window head out of range")
  `ASSERT_SYNC(a_clear_empties, cmd.clear |=> cleared, "clear left state behind")

endmodule

/* hw/rtl/snr_median_peak_decline_detector_top.sv */
// SNR median peak decline detector, top level: APB register file plus
// controller and datapath. Depends on smpd_pkg, smpd_ctrl, smpd_datapath.
//
// Each accepted word is handled alone. A clear word or a gated sample goes
// straight to the result; other samples pass the spacing check (squaring dx, dy
// and the spacing, then comparing) and are rejected or enter the window; the
// first sample after reset or a clear skips the spacing check. When the window
// of n entries (n = window_size forced odd, clamped to the largest odd value
// not above MAX_WINDOW) is full, the median is found by ranking candidates in
// time order, each candidate scanned against the single read port of the
// window memory; a word ranks between one and n candidates. The result is held
// in an output register, so the next word is accepted while it waits; a word
// that finishes before that result is taken holds in its last cycle until it is.

module snr_median_peak_decline_detector_top import smpd_pkg::*; #(
  parameter int MAX_WINDOW = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic               action,
  input  logic               searching,
  input  logic               position_valid,
  input  logic signed [15:0] snr_value,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               sample_taken,
  output logic               filtered_valid,
  output logic signed [15:0] median_snr,
  output logic               new_peak,
  output logic               have_peak,
  output logic signed [15:0] peak_snr,
  output logic signed [15:0] peak_x,
  output logic signed [15:0] peak_y,
  output logic [7:0]         decline_count,
  output logic               return_request
);

  logic [15:0] spacing;
  logic [14:0] drop_threshold;
  logic [7:0]  decline_limit;
  logic [3:0]  window_size;
  reg_idx_t    reg_idx;
  logic        reg_write;

  smpd_cmd_t   cmd;
  smpd_stat_t  stat;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing        <= 16'd38;
      drop_threshold <= 15'd512;
      decline_limit  <= 8'd5;
      window_size    <= 4'd3;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_SPACING: spacing        <= pwdata[15:0];
        REG_DROP:    drop_threshold <= pwdata[14:0];
        REG_LIMIT:   decline_limit  <= pwdata[7:0];
        REG_WSIZE:   window_size    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPACING: prdata = {16'd0, spacing};
      REG_DROP:    prdata = {17'd0, drop_threshold};
      REG_LIMIT:   prdata = {24'd0, decline_limit};
      REG_WSIZE:   prdata = {28'd0, window_size};
      default:     prdata = '0;
    endcase
  end

  smpd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  smpd_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .spacing        (spacing),
    .drop_threshold (drop_threshold),
    .decline_limit  (decline_limit),
    .window_size    (window_size),
    .action         (action),
    .searching      (searching),
    .position_valid (position_valid),
    .snr_value      (snr_value),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .sample_taken   (sample_taken),
    .filtered_valid (filtered_valid),
    .median_snr     (median_snr),
    .new_peak       (new_peak),
    .have_peak      (have_peak),
    .peak_snr       (peak_snr),
    .peak_x         (peak_x),
    .peak_y         (peak_y),
    .decline_count  (decline_count),
    .return_request (return_request)
  );

endmodule

/* test/tb_snr_median_peak_decline_detector_top.sv */
// Testbench for snr_median_peak_decline_detector_top: directed and random sample words
// with an in-bench median/peak/decline predictor and a scoreboard of expected words.
// Depends only on the detector RTL (top, controller, datapath, package).
module tb_snr_median_peak_decline_detector_top import smpd_pkg::*; ();

  localparam int WIN_MAX = 15;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic {
    ACT_CLEAR  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic               action;
    logic               searching;
    logic               pos_valid;
    logic signed [15:0] snr;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } sample_word_t;

  typedef struct {
    logic               taken;
    logic               fvalid;
    logic signed [15:0] fsnr;
    logic               new_pk;
    logic               have_pk;
    logic signed [15:0] pk_snr;
    logic signed [15:0] pk_x;
    logic signed [15:0] pk_y;
    logic [7:0]         declines;
    logic               ret_req;
  } detect_word_t;

  class decline_scoreboard;
    logic signed [15:0] win_snr [WIN_MAX];
    logic signed [15:0] win_x [WIN_MAX];
    logic signed [15:0] win_y [WIN_MAX];
    int                 fill;
    logic signed [15:0] last_x, last_y;
    logic               have_last;
    logic signed [15:0] held_snr, held_x, held_y;
    logic               peak_seen;
    logic [7:0]         declines;
    logic               ret_latched;
    logic [15:0]        spacing;
    logic [14:0]        drop_thr;
    logic [7:0]         limit;
    logic [3:0]         wsize;
    detect_word_t       pending [$];
    int                 fails;

    function new();
      spacing = 16'd38;
      drop_thr = 15'd512;
      limit = 8'd5;
      wsize = 4'd3;
      fails = 0;
      clear_state();
    endfunction

    function void clear_state();
      fill = 0;
      last_x = '0;
      last_y = '0;
      have_last = 1'b0;
      held_snr = '0;
      held_x = '0;
      held_y = '0;
      peak_seen = 1'b0;
      declines = '0;
      ret_latched = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_SPACING: spacing = val[15:0];
        REG_DROP:    drop_thr = val[14:0];
        REG_LIMIT:   limit = val[7:0];
        REG_WSIZE:   wsize = val[3:0];
        default: ;
      endcase
    endfunction

    function int window_len();
      int w;
      w = int'(wsize) | 1;
      if (w > WIN_MAX) begin
        w = WIN_MAX;
        if (w % 2 == 0) w--;
      end
      return w;
    endfunction

    // Insertion sort over a copy of the window, in time order.
    function logic signed [15:0] median_of(int n);
      logic signed [15:0] v [WIN_MAX];
      logic signed [15:0] cur;
      int i, j;
      for (i = 0; i < n; i++) begin
        cur = win_snr[i];
        j = i;
        while (j > 0 && v[j - 1] > cur) begin
          v[j] = v[j - 1];
          j--;
        end
        v[j] = cur;
      end
      return v[n / 2];
    endfunction

    function void note_word(sample_word_t w);
      detect_word_t e;
      longint       dx, dy, d2, s2;
      int           wl, n, i, drop;
      logic         far;
      e = '{default: '0};
      if (w.action == ACT_CLEAR) begin
        clear_state();
      end else if (w.searching && w.pos_valid) begin
        far = 1'b1;
        if (have_last) begin
          dx = longint'(w.x) - longint'(last_x);
          dy = longint'(w.y) - longint'(last_y);
          d2 = dx * dx + dy * dy;
          s2 = longint'(spacing) * longint'(spacing);
          far = (d2 >= s2);
        end
        if (far) begin
          wl = window_len();
          e.taken = 1'b1;
          last_x = w.x;
          last_y = w.y;
          have_last = 1'b1;
          // drop oldest entries so the new one fits the current length
          if (fill >= wl) begin
            n = fill - wl + 1;
            for (i = 0; i + n < fill; i++) begin
              win_snr[i] = win_snr[i + n];
              win_x[i] = win_x[i + n];
              win_y[i] = win_y[i + n];
            end
            fill -= n;
          end
          win_snr[fill] = w.snr;
          win_x[fill] = w.x;
          win_y[fill] = w.y;
          fill++;
          if (fill == wl) begin
            e.fvalid = 1'b1;
            e.fsnr = median_of(fill);
            if (!peak_seen || e.fsnr > held_snr) begin
              peak_seen = 1'b1;
              held_snr = e.fsnr;
              held_x = win_x[fill / 2];
              held_y = win_y[fill / 2];
              declines = '0;
              e.new_pk = 1'b1;
            end else begin
              drop = int'(held_snr) - int'(e.fsnr);
              if (drop >= int'(drop_thr)) begin
                if (declines != 8'hFF) declines++;
              end else begin
                declines = '0;
              end
              if (declines >= limit) ret_latched = 1'b1;
            end
          end
        end
      end
      e.have_pk = peak_seen;
      e.pk_snr = held_snr;
      e.pk_x = held_x;
      e.pk_y = held_y;
      e.declines = declines;
      e.ret_req = ret_latched;
      pending.insert(pending.size(), e);
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
        fails++;
      end
    endfunction

    function void check_result(detect_word_t got);
      detect_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing pending");
        fails++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      cmp("sample_taken", 16'(e.taken), 16'(got.taken));
      cmp("filtered_valid", 16'(e.fvalid), 16'(got.fvalid));
      cmp("median_snr", e.fsnr, got.fsnr);
      cmp("new_peak", 16'(e.new_pk), 16'(got.new_pk));
      cmp("have_peak", 16'(e.have_pk), 16'(got.have_pk));
      cmp("peak_snr", e.pk_snr, got.pk_snr);
      cmp("peak_x", e.pk_x, got.pk_x);
      cmp("peak_y", e.pk_y, got.pk_y);
      cmp("decline_count", 16'(e.declines), 16'(got.declines));
      cmp("return_request", 16'(e.ret_req), 16'(got.ret_req));
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  logic               action = 1'b0;
  logic               searching = 1'b0;
  logic               position_valid = 1'b0;
  logic signed [15:0] snr_value = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               sample_taken;
  logic               filtered_valid;
  logic signed [15:0] median_snr;
  logic               new_peak;
  logic               have_peak;
  logic signed [15:0] peak_snr;
  logic signed [15:0] peak_x;
  logic signed [15:0] peak_y;
  logic [7:0]         decline_count;
  logic               return_request;

  decline_scoreboard  sb = new();
  idle_mode_t         idle_mode = IDLE_NONE;
  int                 items_sent = 0;
  int                 quiet_cycles = 0;
  int                 snr_level = 0;
  int                 snr_trend = 1;
  logic signed [15:0] last_snr = '0;

  snr_median_peak_decline_detector_top dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .action         (action),
    .searching      (searching),
    .position_valid (position_valid),
    .snr_value      (snr_value),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .sample_taken   (sample_taken),
    .filtered_valid (filtered_valid),
    .median_snr     (median_snr),
    .new_peak       (new_peak),
    .have_peak      (have_peak),
    .peak_snr       (peak_snr),
    .peak_x         (peak_x),
    .peak_y         (peak_y),
    .decline_count  (decline_count),
    .return_request (return_request)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    int recv_pct;
    recv_pct = (idle_mode == IDLE_RECV) ? 52 : (idle_mode == IDLE_BOTH) ? 15 : 0;
    result_ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  always @(posedge clk) begin
    detect_word_t got;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (result_valid && result_ready) begin
        got.taken = sample_taken;
        got.fvalid = filtered_valid;
        got.fsnr = median_snr;
        got.new_pk = new_peak;
        got.have_pk = have_peak;
        got.pk_snr = peak_snr;
        got.pk_x = peak_x;
        got.pk_y = peak_y;
        got.declines = decline_count;
        got.ret_req = return_request;
        sb.check_result(got);
      end
      if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
          (psel && penable && pwrite && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(logic act, logic srch, logic pv, logic signed [15:0] snr,
                           logic signed [15:0] x, logic signed [15:0] y);
    sample_word_t w;
    int           pct;
    pct = (idle_mode == IDLE_SEND) ? 52 : (idle_mode == IDLE_BOTH) ? 15 : 0;
    while ($urandom_range(0, 99) < pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    action <= act;
    searching <= srch;
    position_valid <= pv;
    snr_value <= snr;
    pos_x <= x;
    pos_y <= y;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    w = '{act, srch, pv, snr, x, y};
    sb.note_word(w);
    items_sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(int'(idx) * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Hold off the sender until every pending word has come back.
  task automatic release_and_drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int sp, int dr, int lim, int ws, int count, bit pause_mid);
    int                 k, pick, mag, nx, ny, r, step;
    logic               act, srch, pv;
    logic signed [15:0] snr, x, y;
    release_and_drain();
    write_reg(REG_SPACING, 32'(sp));
    write_reg(REG_DROP, 32'(dr));
    write_reg(REG_LIMIT, 32'(lim));
    write_reg(REG_WSIZE, 32'(ws));
    for (k = 0; k < count; k++) begin
      idle_mode = idle_mode_t'((items_sent / 60) % 4);
      if (pause_mid && k == count / 2) release_and_drain();
      pick = $urandom_range(0, 99);
      act = ACT_SAMPLE;
      srch = 1'b1;
      pv = 1'b1;
      snr = 16'($urandom);
      x = 16'($urandom);
      y = 16'($urandom);
      if (pick < 3) begin
        act = ACT_CLEAR;
        srch = 1'($urandom_range(0, 1));
        pv = 1'($urandom_range(0, 1));
      end else if (pick < 8) begin
        srch = 1'b0;
        pv = 1'($urandom_range(0, 1));
      end else if (pick < 13) begin
        srch = 1'($urandom_range(0, 1));
        pv = 1'b0;
      end else if (pick < 20) begin
        // land inside the spacing of the last used sample
        r = $urandom_range(0, int'(sb.spacing) / 2);
        nx = int'(sb.last_x) + r;
        if (nx > 32767) nx = int'(sb.last_x) - r;
        x = 16'(nx);
        y = sb.last_y;
      end else begin
        mag = int'(sb.spacing) + int'($urandom_range(0, 200));
        if ($urandom_range(0, 1)) mag = -mag;
        nx = int'(sb.last_x) + mag;
        if (nx > 32767 || nx < -32768) nx = int'(sb.last_x) - mag;
        if (nx > 32767 || nx < -32768) begin
          // spacing too wide for one axis: jump to the opposite corner
          nx = (sb.last_x < 0) ? 32767 : -32768;
          ny = (sb.last_y < 0) ? 32767 : -32768;
        end else begin
          r = $urandom_range(0, 128);
          ny = int'(sb.last_y) + r - 64;
          if (ny > 32767) ny = 32767;
          if (ny < -32768) ny = -32768;
        end
        x = 16'(nx);
        y = 16'(ny);
        // drift the SNR along a trend that flips now and then
        if ($urandom_range(0, 19) == 0) snr_trend = -snr_trend;
        step = $urandom_range(0, 600);
        snr_level += snr_trend * (step - 200);
        if (snr_level > 30000) begin
          snr_level = 30000;
          snr_trend = -1;
        end
        if (snr_level < -30000) begin
          snr_level = -30000;
          snr_trend = 1;
        end
        r = $urandom_range(0, 9);
        if (r == 0) last_snr = 16'($urandom);
        else if (r != 1) last_snr = 16'(snr_level);
        snr = last_snr;
      end
      send_word(act, srch, pv, snr, x, y);
    end
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the reset settings
    send_word(ACT_CLEAR, 1'b1, 1'b1, -16'sd1, -16'sd1, -16'sd1);
    send_word(ACT_SAMPLE, 1'b0, 1'b1, 16'sd100, 16'sd0, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b0, 16'sd100, 16'sd0, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sh7FFF, 16'sd0, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sd5, 16'sd10, 16'sd10);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sd0, 16'sh7FFF, 16'sh8000);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    for (k = 1; k <= 7; k++)
      send_word(ACT_SAMPLE, 1'b1, 1'b1, -16'sd1000, 16'(100 * k), 16'sd0);
    // one short of the spacing, then exactly on it
    send_word(ACT_SAMPLE, 1'b1, 1'b1, -16'sd1000, 16'sd737, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, -16'sd1000, 16'sd738, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sd20000, 16'sd1000, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sd20000, 16'sd2000, 16'sd0);
    send_word(ACT_CLEAR, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0);
    send_word(ACT_SAMPLE, 1'b1, 1'b1, 16'sd300, 16'sd2000, 16'sd0);

    run_phase(3, 0, 255, 1, 300, 1'b0);
    run_phase(65535, 32767, 255, 15, 120, 1'b0);
    run_phase(38, 512, 5, 3, 250, 1'b1);
    run_phase(100, 256, 0, 5, 200, 1'b0);
    run_phase(20, 300, 3, 14, 150, 1'b0);
    run_phase(0, 1, 1, 0, 200, 1'b0);
    run_phase(200, 700, 4, 2, 250, 1'b1);
    run_phase(500, 128, 2, 7, 200, 1'b0);
    run_phase($urandom_range(3, 2000), $urandom_range(0, 4000), $urandom_range(1, 10),
              $urandom_range(0, 15), 180, 1'b0);

    release_and_drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
